// ===== sv/drl_pkg.sv =====
// ----------------------------------------------------------------------------
// drl_pkg
// Types and constants shared by the downmix linear resampler files.
// ----------------------------------------------------------------------------
package drl_pkg;

    localparam int MAX_CHANNELS      = 8;
    localparam int MAX_PACKET_FRAMES = 4096;
    localparam int RESULT_CAP        = 32;
    localparam int STEP_LOW          = 4096;
    localparam int STEP_HIGH         = 4194304;
    localparam int CH_RESET          = 2;
    localparam int STEP_RESET        = 196608;

    localparam int SAMPLE_W    = 16;
    localparam int FRAMES_W    = 13;
    localparam int CHCNT_W     = 4;
    localparam int STEP_W      = 23;
    localparam int CFG_DATA_W  = 23;
    localparam int CFG_INDEX_W = 1;
    localparam int FRAC_W      = 16;
    localparam int POS_W       = 32;
    localparam int LIMIT_W     = 30;
    localparam int OUTS_W      = 17;
    localparam int SUM_W       = 19;
    localparam int PROD_W      = 2 * (SAMPLE_W + 1);
    localparam int COUNT_W     = 6;
    localparam int DIV_NUM_W   = 30;
    localparam int DIV_DEN_W   = 24;
    localparam int DIV_CNT_W   = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHANNEL_COUNT = 1'b0,
        REG_RATE_STEP     = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        DIV_MONO = 1'b0,
        DIV_OUTS = 1'b1
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_MONO_GO,
        S_MONO_WAIT,
        S_OUTS_GO,
        S_OUTS_WAIT,
        S_LIMIT,
        S_EVAL,
        S_CALC,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] chan;
        logic [FRAMES_W-1:0]                   packet_frames;
        logic                                  silent;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       packet_end;
        logic                       run_end;
    } sample_t;

    typedef struct packed {
        logic     capture;
        logic     load_sum;
        logic     div_start;
        div_sel_t div_sel;
        logic     latch_mono;
        logic     latch_outs;
        logic     load_limit;
        logic     eval_load;
        logic     emit;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic more;
        logic pending_valid;
        logic out_free;
    } status_t;

endpackage

// ===== sv/drl_in_if.sv =====
// ----------------------------------------------------------------------------
// drl_in_if
// Frame channel: one interleaved PCM frame per item.
// ----------------------------------------------------------------------------
interface drl_in_if
    import drl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] chan0;
    logic signed [SAMPLE_W-1:0] chan1;
    logic signed [SAMPLE_W-1:0] chan2;
    logic signed [SAMPLE_W-1:0] chan3;
    logic signed [SAMPLE_W-1:0] chan4;
    logic signed [SAMPLE_W-1:0] chan5;
    logic signed [SAMPLE_W-1:0] chan6;
    logic signed [SAMPLE_W-1:0] chan7;
    logic [FRAMES_W-1:0]        packet_frames;
    logic                       silent;

    modport source (
        output valid, chan0, chan1, chan2, chan3, chan4, chan5, chan6, chan7,
        output packet_frames, silent,
        input  ready
    );

    modport sink (
        input  valid, chan0, chan1, chan2, chan3, chan4, chan5, chan6, chan7,
        input  packet_frames, silent,
        output ready
    );
endinterface

// ===== sv/drl_out_if.sv =====
// ----------------------------------------------------------------------------
// drl_out_if
// Sample channel: one resampled mono sample per item.
// ----------------------------------------------------------------------------
interface drl_out_if
    import drl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       packet_end;
    logic                       run_end;

    modport source (
        output valid, sample_out, packet_end, run_end,
        input  ready
    );

    modport sink (
        input  valid, sample_out, packet_end, run_end,
        output ready
    );
endinterface

// ===== sv/drl_div.sv =====
// ----------------------------------------------------------------------------
// drl_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drl_div
    import drl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic [DIV_DEN_W-1:0] acc_reg, acc_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign trial = {acc_reg, quo_reg[DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/drl_datapath.sv =====
// ----------------------------------------------------------------------------
// drl_datapath
// Configuration, downmix, output count, interpolation and result registers.
// ----------------------------------------------------------------------------
module drl_datapath
    import drl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  frame_t                 frame_in,
    input  cmd_t                   cmd,
    output status_t                st,
    input  logic                   out_ready,
    output logic                   out_valid,
    output sample_t                out_item
);

    localparam int IDX_W = POS_W - FRAC_W;

    // configuration
    logic [CHCNT_W-1:0] chcnt_reg, chcnt_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    // captured item
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] chan_reg, chan_next;
    logic                       silent_reg, silent_next;
    logic [FRAMES_W-1:0]        frames_reg, frames_next;
    logic [CHCNT_W-1:0]         ch_reg, ch_next;
    logic [STEP_W-1:0]          step_eff_reg, step_eff_next;
    logic                       last_reg, last_next;

    // per item work
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] mono_reg, mono_next;
    logic [OUTS_W-1:0]          outs_reg, outs_next;
    logic [LIMIT_W-1:0]         limit_reg, limit_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SAMPLE_W-1:0] base_reg, base_next;
    logic signed [SAMPLE_W-1:0] pending_reg, pending_next;

    // packet state
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [FRAMES_W-1:0]        fidx_reg, fidx_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic                       pending_valid_reg, pending_valid_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    sample_t                    out_item_reg, out_item_next;

    logic [CHCNT_W-1:0]         ch_eff;
    logic [STEP_W-1:0]          step_eff;
    logic [FRAMES_W-1:0]        frames_eff;
    logic [FRAMES_W:0]          fidx_inc;
    logic signed [SUM_W-1:0]    sum_c;
    logic [SUM_W-1:0]           sum_mag;
    logic [DIV_NUM_W-1:0]       outs_num;
    logic [DIV_NUM_W-1:0]       div_num;
    logic [DIV_DEN_W-1:0]       div_den;
    logic                       div_busy;
    logic                       div_done;
    logic [DIV_NUM_W-1:0]       div_quo;
    logic [SAMPLE_W:0]          quo_neg;
    logic [OUTS_W+STEP_W-1:0]   lim_c;
    logic [IDX_W-1:0]           idx;
    logic                       idx_lt;
    logic                       more;
    logic signed [SAMPLE_W:0]   diff_s;
    logic signed [SAMPLE_W:0]   frac_s;
    logic signed [PROD_W-1:0]   prod_c;
    logic signed [PROD_W-1:0]   interp_c;
    logic                       out_free;
    logic                       load_out;

    // ---- configuration writes ----
    always_comb
    begin
        chcnt_next = chcnt_reg;
        step_next  = step_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CHANNEL_COUNT: chcnt_next = cfg_data[CHCNT_W-1:0];
                REG_RATE_STEP:     step_next  = cfg_data[STEP_W-1:0];
            endcase
        end
    end

    // ---- clamps ----
    always_comb
    begin
        priority if (chcnt_reg == '0)
            ch_eff = CHCNT_W'(1);
        else if (chcnt_reg > CHCNT_W'(MAX_CHANNELS))
            ch_eff = CHCNT_W'(MAX_CHANNELS);
        else
            ch_eff = chcnt_reg;

        priority if (step_reg < STEP_W'(STEP_LOW))
            step_eff = STEP_W'(STEP_LOW);
        else if (step_reg > STEP_W'(STEP_HIGH))
            step_eff = STEP_W'(STEP_HIGH);
        else
            step_eff = step_reg;

        priority if (frame_in.packet_frames == '0)
            frames_eff = FRAMES_W'(1);
        else if (frame_in.packet_frames > FRAMES_W'(MAX_PACKET_FRAMES))
            frames_eff = FRAMES_W'(MAX_PACKET_FRAMES);
        else
            frames_eff = frame_in.packet_frames;
    end

    assign fidx_inc = {1'b0, fidx_reg} + (FRAMES_W+1)'(1);

    // ---- channel sum ----
    always_comb
    begin
        sum_c = '0;
        for (int k = 0; k < MAX_CHANNELS; k++)
        begin
            if (CHCNT_W'(k) < ch_reg)
                sum_c = sum_c + SUM_W'(signed'(chan_reg[k]));
        end
    end

    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign outs_num = {frames_reg, {(FRAC_W+1){1'b0}}} + DIV_NUM_W'(step_eff_reg);

    assign div_num = (cmd.div_sel == DIV_OUTS) ? outs_num : DIV_NUM_W'(sum_mag);
    assign div_den = (cmd.div_sel == DIV_OUTS) ? {step_eff_reg, 1'b0}
                                               : DIV_DEN_W'(ch_reg);

    drl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign quo_neg = (SAMPLE_W+1)'(0) - div_quo[SAMPLE_W:0];
    assign lim_c   = outs_reg * step_eff_reg;

    // ---- output position test ----
    assign idx    = pos_reg[POS_W-1:FRAC_W];
    assign idx_lt = idx < IDX_W'(fidx_reg);
    assign more   = (pos_reg < POS_W'(limit_reg))
                 && (count_reg < COUNT_W'(RESULT_CAP))
                 && (idx_lt || last_reg);

    assign diff_s   = {mono_reg[SAMPLE_W-1], mono_reg} - {prev_reg[SAMPLE_W-1], prev_reg};
    assign frac_s   = {1'b0, pos_reg[FRAC_W-1:0]};
    assign prod_c   = frac_s * diff_s;
    // floor of the scaled difference: arithmetic shift rounds toward minus infinity
    assign interp_c = PROD_W'(base_reg) + (prod_reg >>> FRAC_W);

    assign out_free = !out_valid_reg || out_ready;

    // ---- result register ----
    always_comb
    begin
        load_out      = 1'b0;
        out_item_next = out_item_reg;
        if (cmd.emit && pending_valid_reg)
        begin
            load_out                 = 1'b1;
            out_item_next.sample_out = pending_reg;
            out_item_next.packet_end = 1'b0;
            out_item_next.run_end    = 1'b0;
        end
        else if (cmd.finish && pending_valid_reg)
        begin
            load_out                 = 1'b1;
            out_item_next.sample_out = pending_reg;
            out_item_next.packet_end = last_reg;
            out_item_next.run_end    = 1'b1;
        end

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ---- work registers ----
    always_comb
    begin
        chan_next          = chan_reg;
        silent_next        = silent_reg;
        frames_next        = frames_reg;
        ch_next            = ch_reg;
        step_eff_next      = step_eff_reg;
        last_next          = last_reg;
        sum_next           = sum_reg;
        mono_next          = mono_reg;
        outs_next          = outs_reg;
        limit_next         = limit_reg;
        prod_next          = prod_reg;
        base_next          = base_reg;
        pending_next       = pending_reg;
        pos_next           = pos_reg;
        fidx_next          = fidx_reg;
        prev_next          = prev_reg;
        count_next         = count_reg;
        pending_valid_next = pending_valid_reg;

        if (cmd.capture)
        begin
            chan_next     = frame_in.chan;
            silent_next   = frame_in.silent;
            frames_next   = frames_eff;
            ch_next       = ch_eff;
            step_eff_next = step_eff;
            last_next     = fidx_inc >= {1'b0, frames_eff};
        end

        if (cmd.load_sum)
            sum_next = sum_c;

        if (cmd.latch_mono)
        begin
            if (silent_reg)
                mono_next = '0;
            else if (sum_reg[SUM_W-1])
                mono_next = quo_neg[SAMPLE_W-1:0];
            else
                mono_next = div_quo[SAMPLE_W-1:0];
        end

        if (cmd.latch_outs)
            outs_next = (div_quo == '0) ? OUTS_W'(1) : div_quo[OUTS_W-1:0];

        if (cmd.load_limit)
            limit_next = lim_c[LIMIT_W-1:0];

        if (cmd.eval_load)
        begin
            prod_next = idx_lt ? prod_c : '0;
            base_next = idx_lt ? prev_reg : mono_reg;
        end

        if (cmd.emit)
        begin
            pending_next       = interp_c[SAMPLE_W-1:0];
            pending_valid_next = 1'b1;
            pos_next           = pos_reg + POS_W'(step_eff_reg);
            count_next         = count_reg + COUNT_W'(1);
        end

        if (cmd.finish)
        begin
            prev_next          = mono_reg;
            pending_valid_next = 1'b0;
            count_next         = '0;
            if (last_reg)
            begin
                pos_next  = '0;
                fidx_next = '0;
            end
            else
                fidx_next = fidx_inc[FRAMES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chcnt_reg         <= CHCNT_W'(CH_RESET);
            step_reg          <= STEP_W'(STEP_RESET);
            pos_reg           <= '0;
            fidx_reg          <= '0;
            prev_reg          <= '0;
            count_reg         <= '0;
            pending_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            chcnt_reg         <= chcnt_next;
            step_reg          <= step_next;
            pos_reg           <= pos_next;
            fidx_reg          <= fidx_next;
            prev_reg          <= prev_next;
            count_reg         <= count_next;
            pending_valid_reg <= pending_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg     <= chan_next;
        silent_reg   <= silent_next;
        frames_reg   <= frames_next;
        ch_reg       <= ch_next;
        step_eff_reg <= step_eff_next;
        last_reg     <= last_next;
        sum_reg      <= sum_next;
        mono_reg     <= mono_next;
        outs_reg     <= outs_next;
        limit_reg    <= limit_next;
        prod_reg     <= prod_next;
        base_reg     <= base_next;
        pending_reg  <= pending_next;
        out_item_reg <= out_item_next;
    end

    assign st.div_busy      = div_busy;
    assign st.div_done      = div_done;
    assign st.more          = more;
    assign st.pending_valid = pending_valid_reg;
    assign st.out_free      = out_free;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // a held sample is only pushed into a free result register
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && pending_valid_reg) |-> out_free)
        else $error("result register overwritten while full");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> pending_valid_reg)
        else $error("emitted sample not held");

    a_outs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_outs |=> (outs_reg != '0))
        else $error("packet output count is zero");

endmodule

// ===== sv/drl_ctrl.sv =====
// ----------------------------------------------------------------------------
// drl_ctrl
// Sequencer: downmix, two divisions, output limit, then one result per pass.
// ----------------------------------------------------------------------------
module drl_ctrl
    import drl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_SUM;
            S_SUM:       state_next = S_MONO_GO;
            S_MONO_GO:   state_next = S_MONO_WAIT;
            S_MONO_WAIT: if (st.div_done) state_next = S_OUTS_GO;
            S_OUTS_GO:   state_next = S_OUTS_WAIT;
            S_OUTS_WAIT: if (st.div_done) state_next = S_LIMIT;
            S_LIMIT:     state_next = S_EVAL;
            S_EVAL:      state_next = st.more ? S_CALC : S_FLUSH;
            S_CALC:      if (!st.pending_valid || st.out_free) state_next = S_EVAL;
            S_FLUSH:     if (!st.pending_valid || st.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_SUM:       cmd.load_sum = 1'b1;
            S_MONO_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MONO;
            end
            S_MONO_WAIT: cmd.latch_mono = st.div_done;
            S_OUTS_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_OUTS;
            end
            S_OUTS_WAIT: cmd.latch_outs = st.div_done;
            S_LIMIT:     cmd.load_limit = 1'b1;
            S_EVAL:      cmd.eval_load  = st.more;
            // hold while the previous sample cannot leave
            S_CALC:      cmd.emit   = !st.pending_valid || st.out_free;
            S_FLUSH:     cmd.finish = !st.pending_valid || st.out_free;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        st.div_done |-> (state_reg == S_MONO_WAIT || state_reg == S_OUTS_WAIT))
        else $error("divider finished outside a wait state");

    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !st.div_busy)
        else $error("divider restarted while busy");

    a_calc_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC)
            |-> ($past(state_reg) == S_EVAL || $past(state_reg) == S_CALC))
        else $error("interpolation without position test");

endmodule

// ===== sv/downmix_linear_resampler.sv =====
// ----------------------------------------------------------------------------
// downmix_linear_resampler
// Averages each PCM frame to mono and resamples it by linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   src carries one frame per item (chan0..chan7, packet_frames, silent);
//   an item is taken when src.valid and src.ready are both high.
//   dst carries the resampled mono samples; each item gives zero or more
//   results, run_end marks the last of them and packet_end the packet's last.
//   cfg_we/cfg_index/cfg_data write channel_count (0) and rate_step (1);
//   write them only while the block is idle.
// Sequence:
//   One item at a time. Each item makes two passes through the shared
//   30-step restoring divider (mono average, then the packet's output
//   count), then a position test and an interpolation multiply per result.
// Reset:
//   Clears the packet position, frame index and previous mono sample and
//   loads channel_count = 2, rate_step = 3.0 (Q7.16).
// Stall:
//   A finished sample waits in the output register; a held dst.ready halts
//   the sequencer before the next sample would overwrite it.
// ----------------------------------------------------------------------------
module downmix_linear_resampler
    import drl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    drl_in_if.sink                 src,
    drl_out_if.source              dst,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    frame_t  frame_in;
    cmd_t    cmd;
    status_t st;
    logic    in_ready;
    logic    out_valid;
    sample_t out_item;

    assign frame_in.chan[0]       = src.chan0;
    assign frame_in.chan[1]       = src.chan1;
    assign frame_in.chan[2]       = src.chan2;
    assign frame_in.chan[3]       = src.chan3;
    assign frame_in.chan[4]       = src.chan4;
    assign frame_in.chan[5]       = src.chan5;
    assign frame_in.chan[6]       = src.chan6;
    assign frame_in.chan[7]       = src.chan7;
    assign frame_in.packet_frames = src.packet_frames;
    assign frame_in.silent        = src.silent;

    drl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (src.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    drl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame_in  (frame_in),
        .cmd       (cmd),
        .st        (st),
        .out_ready (dst.ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign src.ready      = in_ready;
    assign dst.valid      = out_valid;
    assign dst.sample_out = out_item.sample_out;
    assign dst.packet_end = out_item.packet_end;
    assign dst.run_end    = out_item.run_end;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the downmix linear resampler.
// Feeds PCM frames in packets through a range of channel counts and rate
// steps, predicts every resampled sample on the side and checks each sample
// field by field as it leaves the block, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import drl_pkg::*;

    localparam int IDLE_WAIT   = 200;
    localparam int WATCH_LIMIT = 5000;

    typedef struct packed {
        frame_t frame;
        logic   drain_first;
    } pending_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    drl_in_if  src_if ();
    drl_out_if dst_if ();

    downmix_linear_resampler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src_if),
        .dst       (dst_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies and packet state of the predictor
    logic [CHCNT_W-1:0]         ch_count;
    logic [STEP_W-1:0]          step_q16;
    logic [POS_W-1:0]           next_pos;
    logic [FRAMES_W-1:0]        frame_idx;
    logic signed [SAMPLE_W-1:0] prev_mono;

    pending_t frame_q[$];
    sample_t  sample_q[$];
    frame_t   bus_frame;
    pending_t pick;
    sample_t  want_sample;

    int  frames_planned;
    int  frames_taken;
    int  src_gap;
    int  sink_gap;
    int  idle_pct;
    bit  calm;
    int  errors;
    int  quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int lerp_floor(int lo, int hi, int frac);
        longint prod;
        prod = longint'(frac) * longint'(hi - lo);
        return lo + int'(prod >>> 16);
    endfunction

    // Average one frame to mono and emit every output position it completes.
    function automatic void resample_frame(frame_t f);
        int      chans;
        int      step;
        int      frames;
        int      sum;
        int      mono;
        int      k;
        int      n;
        longint  outs;
        longint  reach;
        bit      closing;
        int      vals[RESULT_CAP];
        sample_t s;

        chans = int'(ch_count);
        if (chans < 1) chans = 1;
        if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;
        step = int'(step_q16);
        if (step < STEP_LOW) step = STEP_LOW;
        if (step > STEP_HIGH) step = STEP_HIGH;
        frames = int'(f.packet_frames);
        if (frames < 1) frames = 1;
        if (frames > MAX_PACKET_FRAMES) frames = MAX_PACKET_FRAMES;

        mono = 0;
        if (!f.silent)
        begin
            sum = 0;
            for (k = 0; k < chans; k++)
                sum += int'($signed(f.chan[k]));
            mono = sum / chans;
        end

        // output count rounds half up, never below one
        outs = ((longint'(frames) << 17) + step) / (longint'(step) * 2);
        if (outs < 1) outs = 1;
        reach = outs * step;
        closing = (int'(frame_idx) + 1 >= frames);

        n = 0;
        while (longint'({32'd0, next_pos}) < reach && n < RESULT_CAP)
        begin
            if (int'(next_pos[31:16]) < int'(frame_idx))
                vals[n] = lerp_floor(int'(prev_mono), mono, int'(next_pos[15:0]));
            else if (closing)
                vals[n] = mono;
            else
                break;
            n++;
            next_pos = next_pos + POS_W'(step);
        end

        for (k = 0; k < n; k++)
        begin
            s.sample_out = SAMPLE_W'(vals[k]);
            s.run_end    = (k == n - 1);
            s.packet_end = (k == n - 1) && closing;
            sample_q = {sample_q, s};
        end

        prev_mono = SAMPLE_W'(mono);
        if (closing)
        begin
            next_pos  = '0;
            frame_idx = '0;
        end
        else
            frame_idx = frame_idx + 1'b1;
    endfunction

    function automatic frame_t rand_frame(int frames);
        frame_t f;
        int     k;
        for (k = 0; k < MAX_CHANNELS; k++)
        begin
            case ($urandom_range(0, 7))
                0:       f.chan[k] = 16'h7FFF;
                1:       f.chan[k] = 16'h8000;
                default: f.chan[k] = 16'($urandom);
            endcase
        end
        f.packet_frames = FRAMES_W'(frames);
        f.silent        = ($urandom_range(0, 7) == 0);
        return f;
    endfunction

    // even channels get one level, odd channels the other
    function automatic frame_t level_frame(logic [15:0] even, logic [15:0] odd,
                                           int frames, bit mute);
        frame_t f;
        int     k;
        for (k = 0; k < MAX_CHANNELS; k++)
            f.chan[k] = (k % 2 == 0) ? even : odd;
        f.packet_frames = FRAMES_W'(frames);
        f.silent        = mute;
        return f;
    endfunction

    function automatic void queue_frame(frame_t f, bit drain);
        pending_t p;
        p.frame       = f;
        p.drain_first = drain;
        frame_q = {frame_q, p};
        frames_planned++;
    endfunction

    // Mostly whole packets with random content; the rest lone frames of any
    // length and packets cut short.
    function automatic void add_random(int count);
        int added;
        int roll;
        int len;
        int cut;
        int i;
        added = 0;
        while (added < count)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
            begin
                queue_frame(rand_frame($urandom_range(0, 8191)), 1'b0);
                added++;
            end
            else
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48)
                                                   : $urandom_range(1, 10);
                cut = (roll == 1) ? $urandom_range(1, len) : len;
                for (i = 0; i < cut; i++)
                    queue_frame(rand_frame(len), (i == 0) && ($urandom_range(0, 19) == 0));
                added += cut;
            end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        // keep the log short on a badly broken build
        if (errors <= 100)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic write_reg(cfg_reg_t which, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == REG_CHANNEL_COUNT)
            ch_count = CHCNT_W'(value);
        else
            step_q16 = STEP_W'(value);
    endtask

    // wait until every frame is taken and every sample is out, then let an
    // item with no result finish as well
    task automatic settle();
        do
            @(posedge clk);
        while (frames_taken != frames_planned || sample_q.size() != 0);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    // frame driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_if.valid <= 1'b0;
            src_gap   = 0;
            next_pos  = '0;
            frame_idx = '0;
            prev_mono = '0;
        end
        else
        begin
            if (src_if.valid && src_if.ready)
            begin
                resample_frame(bus_frame);
                frames_taken++;
                if (!calm && $urandom_range(0, 99) < idle_pct)
                    src_gap = $urandom_range(1, 8);
            end
            if (!src_if.valid || src_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    src_if.valid <= 1'b0;
                end
                else if (frame_q.size() != 0 &&
                         !(frame_q[0].drain_first && sample_q.size() != 0))
                begin
                    pick      = frame_q.pop_front();
                    bus_frame = pick.frame;
                    src_if.valid         <= 1'b1;
                    src_if.chan0         <= bus_frame.chan[0];
                    src_if.chan1         <= bus_frame.chan[1];
                    src_if.chan2         <= bus_frame.chan[2];
                    src_if.chan3         <= bus_frame.chan[3];
                    src_if.chan4         <= bus_frame.chan[4];
                    src_if.chan5         <= bus_frame.chan[5];
                    src_if.chan6         <= bus_frame.chan[6];
                    src_if.chan7         <= bus_frame.chan[7];
                    src_if.packet_frames <= bus_frame.packet_frames;
                    src_if.silent        <= bus_frame.silent;
                end
                else
                    src_if.valid <= 1'b0;
            end
        end
    end

    // sample monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_if.ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (dst_if.valid && dst_if.ready)
            begin
                if (sample_q.size() == 0)
                    report_mismatch("sample with nothing expected",
                                    int'(dst_if.sample_out), 0);
                else
                begin
                    want_sample = sample_q.pop_front();
                    if (dst_if.sample_out !== want_sample.sample_out)
                        report_mismatch("sample_out", int'(dst_if.sample_out),
                                        int'(want_sample.sample_out));
                    if (dst_if.packet_end !== want_sample.packet_end)
                        report_mismatch("packet_end", int'(dst_if.packet_end),
                                        int'(want_sample.packet_end));
                    if (dst_if.run_end !== want_sample.run_end)
                        report_mismatch("run_end", int'(dst_if.run_end),
                                        int'(want_sample.run_end));
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                dst_if.ready <= 1'b0;
            end
            else
            begin
                dst_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < idle_pct)
                    sink_gap = $urandom_range(1, 8);
            end
        end
    end

    // watchdog: too long without any handshake or register write
    always @(posedge clk)
    begin
        if (!rst_n || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready) ||
            cfg_we)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCH_LIMIT)
            begin
                $display("** downmix_linear_resampler: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int ch_plan[5];
        int step_plan[5];
        int idle_plan[5];
        int p;

        ch_plan   = '{15, 9, 8, 1, 5};
        step_plan = '{8388607, 0, 4194304, 4095, 4194305};
        idle_plan = '{50, 20, 40, 25, 15};

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_CHANNEL_COUNT;
        cfg_data     = '0;
        src_if.valid = 1'b0;
        src_if.chan0 = '0;
        src_if.chan1 = '0;
        src_if.chan2 = '0;
        src_if.chan3 = '0;
        src_if.chan4 = '0;
        src_if.chan5 = '0;
        src_if.chan6 = '0;
        src_if.chan7 = '0;
        src_if.packet_frames = '0;
        src_if.silent        = 1'b0;
        dst_if.ready = 1'b0;
        ch_count     = CHCNT_W'(CH_RESET);
        step_q16     = STEP_W'(STEP_RESET);
        calm         = 1'b0;
        idle_pct     = 30;
        errors       = 0;
        frames_planned = 0;
        frames_taken   = 0;
        quiet_cycles   = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // full-scale levels and averages that truncate toward zero
        queue_frame(level_frame(16'h7FFF, 16'h7FFF, 4, 1'b0), 1'b0);
        queue_frame(level_frame(16'h8000, 16'h8000, 4, 1'b0), 1'b0);
        queue_frame(level_frame(16'h8000, 16'h7FFF, 4, 1'b0), 1'b0);
        queue_frame(level_frame(16'hFFFD, 16'h0000, 4, 1'b0), 1'b0);
        // silent frame with live samples; hold it until the packet above is out
        queue_frame(level_frame(16'h7FFF, 16'h7FFF, 2, 1'b1), 1'b1);
        queue_frame(level_frame(16'h1234, 16'hEDCB, 2, 1'b0), 1'b0);
        // zero length counts as a single frame
        queue_frame(level_frame(16'h4000, 16'hC000, 0, 1'b0), 1'b0);
        // oversized packet cut short; the closing frame has nothing left to emit
        repeat (3) queue_frame(rand_frame(8191), 1'b0);
        queue_frame(rand_frame(2), 1'b0);
        // maximum length, then ended by a one-frame length
        queue_frame(rand_frame(4096), 1'b0);
        queue_frame(rand_frame(1), 1'b0);
        queue_frame(rand_frame(1), 1'b0);
        add_random(25);
        settle();

        // zero channels act as one; smallest step
        write_reg(REG_CHANNEL_COUNT, 0);
        write_reg(REG_RATE_STEP, STEP_LOW);
        idle_pct = 0;
        // close any open packet, then flush a cut packet at the result bound
        queue_frame(rand_frame(1), 1'b0);
        repeat (2) queue_frame(rand_frame(4096), 1'b0);
        queue_frame(rand_frame(3), 1'b0);
        add_random(25);
        settle();

        for (p = 0; p < 5; p++)
        begin
            write_reg(REG_CHANNEL_COUNT, ch_plan[p]);
            write_reg(REG_RATE_STEP, step_plan[p]);
            idle_pct = idle_plan[p];
            add_random(25);
            settle();
        end

        // closing stretch at an ordinary setting, no idling
        write_reg(REG_CHANNEL_COUNT, $urandom_range(1, 8));
        write_reg(REG_RATE_STEP, $urandom_range(20000, 300000));
        calm = 1'b1;
        add_random(25);
        settle();

        if (errors == 0)
            $display("** downmix_linear_resampler: PASSED **");
        else
            $display("** downmix_linear_resampler: FAILED **");
        $finish;
    end

endmodule
